// File: design/mta_pkg.sv
// Package for the mosaic tile averaging block: sizes, register indexes,
// the tile record passed from the accumulator to the divider, and state types.
// No dependencies.
package mta_pkg;

  localparam int unsigned MaxTile    = 16;
  localparam int unsigned PixW       = 8;
  localparam int unsigned TileSizeW  = 5;
  localparam int unsigned EdgeW      = $clog2(MaxTile + 1);
  localparam int unsigned CountW     = $clog2(MaxTile * MaxTile + 1);
  localparam int unsigned AlphaSumW  = $clog2(MaxTile * MaxTile * 255 + 1);
  localparam int unsigned ColorSumW  = $clog2(MaxTile * MaxTile * 255 * 255 + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned NumChan    = 4;
  localparam int unsigned StepW      = $clog2(PixW);
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 3;

  localparam logic [TileSizeW-1:0] TileSizeRst = TileSizeW'(4);
  localparam logic                 WeightRst   = 1'b1;

  typedef enum logic {
    REG_TILE_SIZE = 1'b0,
    REG_WEIGHT    = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CH_ALPHA = 2'd0,
    CH_RED   = 2'd1,
    CH_GREEN = 2'd2,
    CH_BLUE  = 2'd3
  } chan_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SETUP,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // Sums of one finished tile, as handed from the accumulator to the divider.
  typedef struct packed {
    logic                 weighted;
    logic [PixW-1:0]      last_alpha;
    logic [CountW-1:0]    count;
    logic [AlphaSumW-1:0] alpha_sum;
    logic [ColorSumW-1:0] red_sum;
    logic [ColorSumW-1:0] green_sum;
    logic [ColorSumW-1:0] blue_sum;
  } tile_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: design/mta_front.sv
// Accumulator front end: takes pixels, sums the channels of the current tile
// and pushes a tile record into the queue on the tile's last pixel.
// Depends on mta_pkg.
module mta_front import mta_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [TileSizeW-1:0] tile_size_i,
  input  logic                 weight_by_alpha_i,
  input  logic                 clear_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PixW-1:0]      alpha_in_i,
  input  logic [PixW-1:0]      red_in_i,
  input  logic [PixW-1:0]      green_in_i,
  input  logic [PixW-1:0]      blue_in_i,
  input  queue_status_t        q_status_i,
  output logic                 push_o,
  output tile_rec_t            rec_o
);

  logic [EdgeW-1:0]     tile_edge;
  logic [2*EdgeW-1:0]   edge_sq;
  logic [CountW-1:0]    total;
  logic [CountW-1:0]    count_q, count_inc;
  logic [AlphaSumW-1:0] alpha_sum_q, alpha_sum_new;
  logic [ColorSumW-1:0] red_sum_q, green_sum_q, blue_sum_q;
  logic [ColorSumW-1:0] red_sum_new, green_sum_new, blue_sum_new;
  logic [ColorSumW-1:0] red_add, green_add, blue_add;
  logic [2*PixW-1:0]    red_prod, green_prod, blue_prod;
  logic                 last_pix;
  logic                 accept;

  // An edge of zero behaves as one, and an edge above the maximum is clamped.
  always_comb begin
    if (tile_size_i == '0) begin
      tile_edge = EdgeW'(1);
    end else if (int'(tile_size_i) > MaxTile) begin
      tile_edge = EdgeW'(MaxTile);
    end else begin
      tile_edge = EdgeW'(tile_size_i);
    end
  end

  assign edge_sq   = (2*EdgeW)'(tile_edge) * (2*EdgeW)'(tile_edge);
  assign total     = CountW'(edge_sq);
  assign count_inc = count_q + 1'b1;
  assign last_pix  = (count_inc >= total);

  assign in_ready_o = !last_pix || !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign red_prod   = (2*PixW)'(red_in_i) * (2*PixW)'(alpha_in_i);
  assign green_prod = (2*PixW)'(green_in_i) * (2*PixW)'(alpha_in_i);
  assign blue_prod  = (2*PixW)'(blue_in_i) * (2*PixW)'(alpha_in_i);

  always_comb begin
    if (weight_by_alpha_i) begin
      red_add   = ColorSumW'(red_prod);
      green_add = ColorSumW'(green_prod);
      blue_add  = ColorSumW'(blue_prod);
    end else begin
      red_add   = ColorSumW'(red_in_i);
      green_add = ColorSumW'(green_in_i);
      blue_add  = ColorSumW'(blue_in_i);
    end
  end

  assign alpha_sum_new = alpha_sum_q + AlphaSumW'(alpha_in_i);
  assign red_sum_new   = red_sum_q + red_add;
  assign green_sum_new = green_sum_q + green_add;
  assign blue_sum_new  = blue_sum_q + blue_add;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      alpha_sum_q <= '0;
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
    end else if (clear_i || (accept && last_pix)) begin
      count_q     <= '0;
      alpha_sum_q <= '0;
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
    end else if (accept) begin
      count_q     <= count_inc;
      alpha_sum_q <= alpha_sum_new;
      red_sum_q   <= red_sum_new;
      green_sum_q <= green_sum_new;
      blue_sum_q  <= blue_sum_new;
    end
  end

  assign push_o = accept && last_pix;

  always_comb begin
    rec_o.weighted   = weight_by_alpha_i;
    rec_o.last_alpha = alpha_in_i;
    rec_o.count      = count_inc;
    rec_o.alpha_sum  = alpha_sum_new;
    rec_o.red_sum    = red_sum_new;
    rec_o.green_sum  = green_sum_new;
    rec_o.blue_sum   = blue_sum_new;
  end

endmodule

// File: design/mta_queue.sv
// Short queue of finished tile records between the accumulator and the divider.
// Depends on mta_pkg.
module mta_queue import mta_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tile_rec_t     rec_i,
  input  logic          pop_i,
  output tile_rec_t     rec_o,
  output queue_status_t status_o
);

  tile_rec_t         entries_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  fill_q;
  logic              do_push, do_pop;

  assign status_o.full  = (fill_q == QCntW'(QueueDepth));
  assign status_o.empty = (fill_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rec_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// File: design/mta_back.sv
// Divider back end: takes tile records from the queue and works out the four
// averages with one shared restoring divider, then holds the result for output.
// Depends on mta_pkg.
module mta_back import mta_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  queue_status_t   q_status_i,
  input  tile_rec_t       rec_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] alpha_out_o,
  output logic [PixW-1:0] red_out_o,
  output logic [PixW-1:0] green_out_o,
  output logic [PixW-1:0] blue_out_o
);

  back_state_e          state_q, state_d;
  tile_rec_t            rec_q;
  chan_e                ch_q;
  logic [StepW-1:0]     step_q;
  logic [AlphaSumW-1:0] rem_q;
  logic [PixW-1:0]      quo_q;
  logic [PixW-1:0]      res_q [NumChan];
  logic                 out_valid_q;
  logic [PixW-1:0]      alpha_out_q, red_out_q, green_out_q, blue_out_q;

  logic [ColorSumW-1:0] num;
  logic [AlphaSumW-1:0] den;
  logic                 bypass;
  logic [PixW-1:0]      bypass_val;
  logic [AlphaSumW:0]   trial, diff;
  logic                 fits;
  logic [PixW-1:0]      quo_next;
  logic                 last_step, last_ch;
  logic                 load_out;

  // Operands of the channel in hand. Colour channels divide by the alpha sum
  // when weighting, otherwise by the pixel count.
  always_comb begin
    unique case (ch_q)
      CH_ALPHA: begin
        num = ColorSumW'(rec_q.alpha_sum);
        den = AlphaSumW'(rec_q.count);
      end
      CH_RED: begin
        num = rec_q.red_sum;
        den = rec_q.weighted ? rec_q.alpha_sum : AlphaSumW'(rec_q.count);
      end
      CH_GREEN: begin
        num = rec_q.green_sum;
        den = rec_q.weighted ? rec_q.alpha_sum : AlphaSumW'(rec_q.count);
      end
      CH_BLUE: begin
        num = rec_q.blue_sum;
        den = rec_q.weighted ? rec_q.alpha_sum : AlphaSumW'(rec_q.count);
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  // A fully transparent weighted tile gives zeros; plain mode passes the
  // last pixel's alpha straight through.
  always_comb begin
    bypass     = 1'b0;
    bypass_val = '0;
    if (rec_q.weighted && (rec_q.alpha_sum == '0)) begin
      bypass = 1'b1;
    end else if (!rec_q.weighted && (ch_q == CH_ALPHA)) begin
      bypass     = 1'b1;
      bypass_val = rec_q.last_alpha;
    end
  end

  // Every quotient is below 256, so the upper numerator bits already sit
  // below the divisor and only eight quotient bits need to be developed.
  assign trial     = {rem_q, quo_q[PixW-1]};
  assign fits      = (trial >= {1'b0, den});
  assign diff      = trial - {1'b0, den};
  assign quo_next  = {quo_q[PixW-2:0], fits};
  assign last_step = (step_q == StepW'(PixW - 1));
  assign last_ch   = (ch_q == CH_BLUE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = BK_SETUP;
        end
      end
      BK_SETUP: begin
        if (bypass) begin
          state_d = last_ch ? BK_DONE : BK_SETUP;
        end else begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_step) begin
          state_d = last_ch ? BK_DONE : BK_SETUP;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == BK_IDLE) && !q_status_i.empty;
    load_out = (state_q == BK_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          rec_q <= rec_i;
          ch_q  <= CH_ALPHA;
        end
      end
      BK_SETUP: begin
        if (bypass) begin
          res_q[ch_q] <= bypass_val;
          ch_q        <= chan_e'(ch_q + 1'b1);
        end else begin
          rem_q  <= AlphaSumW'(num >> PixW);
          quo_q  <= num[PixW-1:0];
          step_q <= '0;
        end
      end
      BK_DIV: begin
        rem_q  <= fits ? diff[AlphaSumW-1:0] : trial[AlphaSumW-1:0];
        quo_q  <= quo_next;
        step_q <= step_q + 1'b1;
        if (last_step) begin
          res_q[ch_q] <= quo_next;
          ch_q        <= chan_e'(ch_q + 1'b1);
        end
      end
      BK_DONE: begin
        if (load_out) begin
          alpha_out_q <= res_q[CH_ALPHA];
          red_out_q   <= res_q[CH_RED];
          green_out_q <= res_q[CH_GREEN];
          blue_out_q  <= res_q[CH_BLUE];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign alpha_out_o = alpha_out_q;
  assign red_out_o   = red_out_q;
  assign green_out_o = green_out_q;
  assign blue_out_o  = blue_out_q;

endmodule

// File: design/mosaic_tile_average.sv
// Top level of the mosaic tile averaging block: configuration registers on an
// APB-style port, the pixel accumulator, the tile queue and the divider.
// Depends on mta_pkg, mta_front, mta_queue and mta_back.

// Pixels of a tile are taken one per cycle while the queue has room for the
// tile's sums; on the tile's last pixel its sums go into a two-entry queue, and
// the result appears after the divider has worked through the four channels.
// The divider settles one quotient bit per cycle and passes some channels
// straight through, and this runs alongside the accumulation of the following
// tiles. Tiles of 49 pixels (an edge of seven) or more stream at one pixel per
// cycle while the output is taken; smaller tiles are limited to one tile per
// divider pass once the queue has filled. Any register write abandons a partly
// accumulated tile.
module mosaic_tile_average import mta_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PixW-1:0]  alpha_in_i,
  input  logic [PixW-1:0]  red_in_i,
  input  logic [PixW-1:0]  green_in_i,
  input  logic [PixW-1:0]  blue_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PixW-1:0]  alpha_out_o,
  output logic [PixW-1:0]  red_out_o,
  output logic [PixW-1:0]  green_out_o,
  output logic [PixW-1:0]  blue_out_o
);

  logic [TileSizeW-1:0] tile_size_q;
  logic                 weight_q;
  logic                 wr_en;
  reg_idx_e             reg_idx;
  logic                 push;
  logic                 pop;
  tile_rec_t            front_rec, queue_rec;
  queue_status_t        q_status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= TileSizeRst;
      weight_q    <= WeightRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TILE_SIZE: tile_size_q <= pwdata[TileSizeW-1:0];
        REG_WEIGHT:    weight_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TILE_SIZE: prdata = DataW'(tile_size_q);
      REG_WEIGHT:    prdata = DataW'(weight_q);
      default:       prdata = '0;
    endcase
  end

  mta_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tile_size_i       (tile_size_q),
    .weight_by_alpha_i (weight_q),
    .clear_i           (wr_en),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .alpha_in_i        (alpha_in_i),
    .red_in_i          (red_in_i),
    .green_in_i        (green_in_i),
    .blue_in_i         (blue_in_i),
    .q_status_i        (q_status),
    .push_o            (push),
    .rec_o             (front_rec)
  );

  mta_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (front_rec),
    .pop_i    (pop),
    .rec_o    (queue_rec),
    .status_o (q_status)
  );

  mta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .rec_i       (queue_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .alpha_out_o (alpha_out_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

endmodule
